// File: rtl/point_line_distance_3d_assert.svh
// Assertion macros for the point-to-line distance block.
// Used by the top level only; no other dependencies.
`ifndef POINT_LINE_DISTANCE_3D_ASSERT_SVH
`define POINT_LINE_DISTANCE_3D_ASSERT_SVH

// Implication checked on every rising edge outside reset
`define PLD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition that must never be seen outside reset
`define PLD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/pld_pkg.sv
// Types and width constants for the point-to-line distance block.
// No dependencies; imported by every module of the block.
package pld_pkg;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned DIST_BITS  = 25;
  // difference, product, cross term and magnitude widths
  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned CW  = PW + 1;
  localparam int unsigned MW  = 2 * DW;
  localparam int unsigned HW  = MW / 2;
  localparam int unsigned A2W = 2 * DW + 2;
  localparam int unsigned C2W = 2 * MW + 2;
  localparam int unsigned WW  = C2W + 3;
  // three front stages, three square stages, one stage per result bit
  localparam int unsigned PIPE_LAT = 6 + DIST_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
  } pld_in_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] line_distance;
    logic                 degenerate;
  } pld_out_t;

  // cross product magnitudes and squared direction length
  typedef struct packed {
    logic                   valid;
    logic [2:0][MW-1:0]     mag;
    logic [A2W-1:0]         a2;
  } pld_front_t;

  // squared cross length and squared direction length
  typedef struct packed {
    logic            valid;
    logic [C2W-1:0]  c2;
    logic [A2W-1:0]  a2;
  } pld_sq_t;

  // state of the bitwise root search
  typedef struct packed {
    logic                 valid;
    logic                 degenerate;
    logic [WW-1:0]        rem;
    logic [WW-1:0]        prod;
    logic [A2W-1:0]       a2;
    logic [DIST_BITS-1:0] dist_code;
  } pld_root_t;

endpackage

// File: rtl/pld_front.sv
// Front stages: differences, cross products, magnitudes, squared direction length.
// Depends on pld_pkg.
module pld_front import pld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  pld_in_t    item_i,
  output pld_front_t front_o
);

  logic                 s1_valid_q;
  logic signed [DW-1:0] a_q [3];
  logic signed [DW-1:0] b_q [3];
  logic                 s2_valid_q;
  logic signed [PW-1:0] p1_q [3];
  logic signed [PW-1:0] p2_q [3];
  logic        [PW-1:0] sa_q [3];
  logic                 s3_valid_q;
  logic [2:0][MW-1:0]   mag_q;
  logic [A2W-1:0]       a2_q;
  logic signed [CW-1:0] c_d [3];

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // form direction and offset
  always_ff @(posedge clk_i) begin
    a_q[0] <= DW'(item_i.end_x) - DW'(item_i.start_x);
    a_q[1] <= DW'(item_i.end_y) - DW'(item_i.start_y);
    a_q[2] <= DW'(item_i.end_z) - DW'(item_i.start_z);
    b_q[0] <= DW'(item_i.query_x) - DW'(item_i.start_x);
    b_q[1] <= DW'(item_i.query_y) - DW'(item_i.start_y);
    b_q[2] <= DW'(item_i.query_z) - DW'(item_i.start_z);
  end

  // multiply cross terms and direction squares
  always_ff @(posedge clk_i) begin
    p1_q[0] <= PW'(a_q[1]) * PW'(b_q[2]);
    p2_q[0] <= PW'(a_q[2]) * PW'(b_q[1]);
    p1_q[1] <= PW'(a_q[2]) * PW'(b_q[0]);
    p2_q[1] <= PW'(a_q[0]) * PW'(b_q[2]);
    p1_q[2] <= PW'(a_q[0]) * PW'(b_q[1]);
    p2_q[2] <= PW'(a_q[1]) * PW'(b_q[0]);
    for (int i = 0; i < 3; i++) begin
      sa_q[i] <= PW'(PW'(a_q[i]) * PW'(a_q[i]));
    end
  end

  // subtract cross terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_d[i] = CW'(p1_q[i]) - CW'(p2_q[i]);
    end
  end

  // take magnitudes, sum direction squares
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mag_q[i] <= c_d[i][CW-1] ? MW'(-c_d[i]) : MW'(c_d[i]);
    end
    a2_q <= A2W'(sa_q[0]) + A2W'(sa_q[1]) + A2W'(sa_q[2]);
  end

  assign front_o.valid = s3_valid_q;
  assign front_o.mag   = mag_q;
  assign front_o.a2    = a2_q;

endmodule

// File: rtl/pld_square.sv
// Square stages: split-operand squares of the cross magnitudes and their sum.
// Depends on pld_pkg.
module pld_square import pld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pld_front_t front_i,
  output pld_sq_t    sq_o
);

  logic              s4_valid_q, s5_valid_q, s6_valid_q;
  logic [2*HW-1:0]   hh_q [3];
  logic [2*HW-1:0]   hl_q [3];
  logic [2*HW-1:0]   ll_q [3];
  logic [A2W-1:0]    a2_s4_q, a2_s5_q, a2_s6_q;
  logic [2*MW-1:0]   sq_q [3];
  logic [C2W-1:0]    c2_q;

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= front_i.valid;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  // multiply high and low halves
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      hh_q[i] <= (2*HW)'(front_i.mag[i][MW-1:HW]) * (2*HW)'(front_i.mag[i][MW-1:HW]);
      hl_q[i] <= (2*HW)'(front_i.mag[i][MW-1:HW]) * (2*HW)'(front_i.mag[i][HW-1:0]);
      ll_q[i] <= (2*HW)'(front_i.mag[i][HW-1:0]) * (2*HW)'(front_i.mag[i][HW-1:0]);
    end
    a2_s4_q <= front_i.a2;
  end

  // combine partial products per axis
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= ((2*MW)'(hh_q[i]) << (2*HW)) + ((2*MW)'(hl_q[i]) << (HW + 1))
               + (2*MW)'(ll_q[i]);
    end
    a2_s5_q <= a2_s4_q;
  end

  // sum the three axes
  always_ff @(posedge clk_i) begin
    c2_q    <= C2W'(sq_q[0]) + C2W'(sq_q[1]) + C2W'(sq_q[2]);
    a2_s6_q <= a2_s5_q;
  end

  assign sq_o.valid = s6_valid_q;
  assign sq_o.c2    = c2_q;
  assign sq_o.a2    = a2_s6_q;

endmodule

// File: rtl/pld_root_stage.sv
// One bit of the distance search: largest t with t*t*|A|^2 <= |C|^2.
// Depends on pld_pkg.
module pld_root_stage import pld_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pld_root_t st_i,
  output pld_root_t st_o
);

  logic [WW-1:0] term_d;
  logic          fits_d;
  pld_root_t     st_q;

  // growth of t*t*a2 when this bit is set: a2*(2*t*2^k + 2^2k)
  always_comb begin
    term_d = (st_i.prod << (Bit + 1)) + (WW'(st_i.a2) << (2 * Bit));
    fits_d = st_i.rem >= term_d;
  end

  // clear valid under reset, otherwise accept or drop the trial bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.valid <= 1'b0;
    end else begin
      st_q.valid      <= st_i.valid;
      st_q.degenerate <= st_i.degenerate;
      st_q.a2         <= st_i.a2;
      if (fits_d) begin
        st_q.rem       <= st_i.rem - term_d;
        st_q.prod      <= st_i.prod + (WW'(st_i.a2) << Bit);
        st_q.dist_code <= st_i.dist_code | (DIST_BITS'(1) << Bit);
      end else begin
        st_q.rem       <= st_i.rem;
        st_q.prod      <= st_i.prod;
        st_q.dist_code <= st_i.dist_code;
      end
    end
  end

  assign st_o = st_q;

endmodule

// File: rtl/point_line_distance_3d.sv
// Perpendicular distance of a 3-D point from a line through two points.
// Usage:
//   Drive item_i and raise start_i; the item is taken at any edge with
//   start_i high and busy_o low. busy_o stays low: one item per cycle.
//   Each result appears on result_o for exactly one cycle with done_o high,
//   in item order, once its item has passed every pipeline stage.
//   Throughput is one item per clock; the pipeline is 3 front stages
//   (differences, products, magnitudes), 3 square stages and one stage per
//   result bit of the square-root-like search (25 stages).
//   line_distance is floor(|A x B| / |A|) on the raw Q12.12 codes, saturated
//   to 25 bits. When the two line points coincide, degenerate is 1 and the
//   distance reads zero.
//   Reset clears all valid bits; items in flight are dropped and no result
//   follows. The receiver cannot stall: results must be taken when shown.
// Depends on pld_pkg, pld_front, pld_square, pld_root_stage and the
// assertion header.
`include "point_line_distance_3d_assert.svh"
module point_line_distance_3d import pld_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  pld_in_t  item_i,
  output logic     done_o,
  output pld_out_t result_o
);

  pld_front_t front;
  pld_sq_t    sq;
  pld_root_t  root [DIST_BITS+1];

  assign busy_o = 1'b0;

  pld_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .item_i  (item_i),
    .front_o (front)
  );

  pld_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front),
    .sq_o    (sq)
  );

  // seed the search with the full remainder
  always_comb begin
    root[0].valid      = sq.valid;
    root[0].degenerate = (sq.a2 == '0);
    root[0].rem        = WW'(sq.c2);
    root[0].prod       = '0;
    root[0].a2         = sq.a2;
    root[0].dist_code  = '0;
  end

  // one stage per result bit, most significant first
  for (genvar i = 0; i < DIST_BITS; i++) begin : g_root
    pld_root_stage #(
      .Bit (DIST_BITS - 1 - i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .st_i   (root[i]),
      .st_o   (root[i+1])
    );
  end

  // drive the result, zero for a degenerate line
  assign done_o                 = root[DIST_BITS].valid;
  assign result_o.degenerate    = root[DIST_BITS].degenerate;
  assign result_o.line_distance = root[DIST_BITS].degenerate ? '0 : root[DIST_BITS].dist_code;

  `PLD_ASSERT_IMPL(a_degen_zero, clk_i, rst_ni, done_o && result_o.degenerate, result_o.line_distance == '0, "degenerate result with nonzero distance")
  `PLD_ASSERT_IMPL(a_done_traced, clk_i, rst_ni, done_o, $past(start_i && !busy_o, PIPE_LAT), "result without an accepted item")
  `PLD_ASSERT_IMPL(a_degen_flag, clk_i, rst_ni, done_o && $past(item_i.start_x == item_i.end_x && item_i.start_y == item_i.end_y && item_i.start_z == item_i.end_z, PIPE_LAT), result_o.degenerate, "coinciding points not flagged")
  `PLD_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o, "pipeline refused an item")

endmodule
